### hdl/fbpa_pkg.sv
// Shared codes and types for the fixed block pool allocator.
// No dependencies; imported by fbpa_ctrl and fixed_block_pool_allocator_unit.
package fbpa_pkg;

    // item mode codes
    localparam logic MODE_ALLOC   = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    // result status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_EMPTY   = 2'd1;
    localparam logic [1:0] STATUS_REFUSED = 2'd2;

    // configuration register indexes
    localparam int unsigned REG_POOL_BLOCKS = 0;

    // block count after reset, before clamping to the pool depth
    localparam int unsigned POOL_RESET_BLOCKS = 64;

    // field widths
    localparam int unsigned IDX_W   = 6;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned COUNT_W = 7;

    typedef enum logic
    {
        SEQ_IDLE,
        SEQ_EXEC
    } seq_state_t;

endpackage

### hdl/fbpa_link_ram.sv
// Next-link memory of the free list: one write port, one registered read port.
// No dependencies; instantiated by fbpa_ctrl.
module fbpa_link_ram
#(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned WIDTH = 8
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/fbpa_ctrl.sv
// Allocate/release sequencer: free-list head, fill mark and result registers.
// Depends on fbpa_pkg and drives one fbpa_link_ram.
module fbpa_ctrl
    import fbpa_pkg::*;
#(
    parameter int unsigned POOL_DEPTH = 64
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                rebuild,
    input  logic [$clog2(POOL_DEPTH+1)-1:0]     pool_count,
    input  logic                                start,
    input  logic                                mode,
    input  logic [IDX_W-1:0]                    block_index,
    output logic                                busy,
    output logic                                done,
    output logic [STAT_W-1:0]                   status,
    output logic [IDX_W-1:0]                    granted_index
);

    localparam int unsigned AW    = $clog2(POOL_DEPTH);
    localparam int unsigned LW    = $clog2(POOL_DEPTH + 1);
    localparam int unsigned CMPW  = (LW > COUNT_W) ? LW : COUNT_W;
    localparam logic [LW-1:0] NULL_LINK = LW'(POOL_DEPTH);

    seq_state_t state_reg, state_next;

    logic [LW-1:0]     head_reg, head_next;
    // entries at or above the fill mark were never written since the last rebuild
    logic [LW-1:0]     fill_reg, fill_next;
    logic              done_reg, done_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [IDX_W-1:0]  granted_reg, granted_next;

    logic              mode_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [AW-1:0]     addr_reg;

    logic              accept;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [LW:0]       rd_data;
    logic              wr_en;
    logic [LW:0]       wr_data;

    logic              touched;
    logic [LW-1:0]     addr_plus;
    logic [LW-1:0]     dflt_link;
    logic [LW-1:0]     ent_link;
    logic              ent_in_use;
    logic              pool_empty;
    logic              rel_refused;

    fbpa_link_ram #(
        .DEPTH (POOL_DEPTH),
        .WIDTH (LW + 1)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (addr_reg),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SEQ_IDLE:
            begin
                if (start)
                begin
                    state_next = SEQ_EXEC;
                end
            end
            SEQ_EXEC:
            begin
                state_next = SEQ_IDLE;
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        busy   = 1'b0;
        accept = 1'b0;
        case (state_reg)
            SEQ_IDLE:
            begin
                accept = start;
            end
            SEQ_EXEC:
            begin
                busy = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    assign rd_en   = accept;
    assign rd_addr = (mode == MODE_RELEASE) ? AW'(block_index) : AW'(head_reg);

    // untouched entries read as the rebuilt chain
    assign touched    = LW'(addr_reg) < fill_reg;
    assign addr_plus  = LW'(addr_reg) + LW'(1);
    assign dflt_link  = (addr_plus < pool_count) ? addr_plus : NULL_LINK;
    assign ent_link   = touched ? rd_data[LW-1:0] : dflt_link;
    assign ent_in_use = touched ? rd_data[LW] : 1'b0;

    assign pool_empty  = head_reg >= pool_count;
    assign rel_refused = (CMPW'(idx_reg) >= CMPW'(pool_count)) || !ent_in_use;

    always_comb
    begin
        head_next    = head_reg;
        fill_next    = fill_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        granted_next = granted_reg;
        wr_en        = 1'b0;
        wr_data      = {1'b1, NULL_LINK};
        if (busy)
        begin
            done_next    = 1'b1;
            status_next  = STATUS_OK;
            granted_next = '0;
            if (mode_reg == MODE_ALLOC)
            begin
                if (pool_empty)
                begin
                    status_next = STATUS_EMPTY;
                end
                else
                begin
                    wr_en        = 1'b1;
                    wr_data      = {1'b1, NULL_LINK};
                    head_next    = ent_link;
                    granted_next = IDX_W'(head_reg);
                    if (!touched)
                    begin
                        fill_next = addr_plus;
                    end
                end
            end
            else
            begin
                if (rel_refused)
                begin
                    status_next = STATUS_REFUSED;
                end
                else
                begin
                    wr_en     = 1'b1;
                    wr_data   = {1'b0, head_reg};
                    head_next = LW'(addr_reg);
                end
            end
        end
        if (rebuild)
        begin
            head_next = '0;
            fill_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_IDLE;
            head_reg  <= '0;
            fill_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            fill_reg  <= fill_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        granted_reg <= granted_next;
        if (accept)
        begin
            mode_reg <= mode;
            idx_reg  <= block_index;
            addr_reg <= rd_addr;
        end
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign granted_index = granted_reg;

endmodule

### hdl/fixed_block_pool_allocator_unit.sv
// Top level of the fixed block pool allocator: APB register and item channel.
// Depends on fbpa_pkg and fbpa_ctrl (which holds fbpa_link_ram).
//
// Usage:
//   Items enter on start/mode/block_index and are taken at a clock edge where
//   start is high and busy is low. mode 0 allocates the free-list head, mode 1
//   releases block_index. Each item gives exactly one result: done is
//   registered from the busy (EXEC) state and is high for one cycle with
//   status and granted_index.
//   The receiver cannot stall; results are simply presented.
//   No new item is taken while busy: the link memory is read on the accept
//   edge and written back at the end of the busy (EXEC) cycle.
//   The pool_blocks register (address 0) sets the block count, clamped to
//   1..POOL_DEPTH; writing it resets the head and the fill mark, so the free
//   list is rebuilt with no clearing pass. Write it only while the block is
//   idle.
//   Reset (rst_n low) sets pool_blocks to 64 (or POOL_DEPTH if smaller) and
//   leaves every block free; the memory contents need no initialisation.
module fixed_block_pool_allocator_unit
    import fbpa_pkg::*;
#(
    parameter int unsigned POOL_DEPTH = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [1:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               start,
    output logic               busy,
    input  logic               mode,
    input  logic [IDX_W-1:0]   block_index,
    output logic               done,
    output logic [STAT_W-1:0]  status,
    output logic [IDX_W-1:0]   granted_index
);

    localparam int unsigned LW   = $clog2(POOL_DEPTH + 1);
    localparam int unsigned CMPW = (LW > COUNT_W) ? LW : COUNT_W;
    localparam int unsigned RESET_COUNT =
        (POOL_DEPTH < POOL_RESET_BLOCKS) ? POOL_DEPTH : POOL_RESET_BLOCKS;

    logic [LW-1:0]   count_reg, count_next;
    logic            cfg_wr;
    logic            cfg_hit;
    logic [CMPW-1:0] wr_val;

    assign pready  = 1'b1;
    assign cfg_hit = paddr == 2'(REG_POOL_BLOCKS);
    assign cfg_wr  = psel && penable && pwrite && pready && cfg_hit;
    assign wr_val  = CMPW'(pwdata[COUNT_W-1:0]);

    always_comb
    begin
        count_next = count_reg;
        if (cfg_wr)
        begin
            if (wr_val == '0)
            begin
                count_next = LW'(1);
            end
            else if (wr_val > CMPW'(POOL_DEPTH))
            begin
                count_next = LW'(POOL_DEPTH);
            end
            else
            begin
                count_next = LW'(wr_val);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= LW'(RESET_COUNT);
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign prdata = cfg_hit ? 32'(count_reg) : '0;

    fbpa_ctrl #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .rebuild       (cfg_wr),
        .pool_count    (count_reg),
        .start         (start),
        .mode          (mode),
        .block_index   (block_index),
        .busy          (busy),
        .done          (done),
        .status        (status),
        .granted_index (granted_index)
    );

    // an accepted item occupies exactly one busy cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_busy_single: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy)
        else $error("busy held for more than one cycle");

    // every result follows the busy cycle of its item
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done)
        else $error("result missing after busy cycle");

    // only a granted allocate carries a nonzero index
    a_granted_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != STATUS_OK) |-> granted_index == '0)
        else $error("nonzero index on failed item");

endmodule
